[rtl/crc_pkg.sv]
// ----------------------------------------------------------------------------
// crc_pkg: shared types and constants of the circle/rectangle resolver
// Field widths, internal datapath widths and the sideband words that ride
// along the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package crc_pkg;
  localparam int FRAC_BITS_DEF = 8;
  localparam int POS_W   = 24;  // signed centre / displacement
  localparam int SIZE_W  = 20;  // unsigned size
  localparam int VEC_W   = 26;  // signed separation vector
  localparam int MAG_W   = 25;  // magnitude of a separation component
  localparam int SQ_W    = 50;  // one square
  localparam int RAD_W   = 52;  // radicand, padded to an even width
  localparam int ROOT_W  = 26;  // integer square root
  localparam int REM_W   = 28;  // square root remainder
  localparam int LIM_W   = 21;  // contact limit, depth, divisor
  localparam int PUSH_W  = 22;  // signed push value
  localparam int SQ_STEPS = RAD_W / 2;

  typedef struct packed {
    logic                     rect_pair;
    logic                     rect_hit;
    logic signed [PUSH_W-1:0] rdx;
    logic signed [PUSH_W-1:0] rdy;
    logic                     dyn;
    logic                     neg;
    logic                     sx;
    logic                     sy;
    logic [LIM_W-1:0]         mx;
    logic [LIM_W-1:0]         my;
    logic [LIM_W-1:0]         lim;
  } crc_tag_t;

  typedef struct packed {
    logic                     rect_pair;
    logic                     rect_hit;
    logic signed [PUSH_W-1:0] rdx;
    logic signed [PUSH_W-1:0] rdy;
    logic                     dyn;
    logic                     neg;
    logic                     sx;
    logic                     sy;
    logic                     hitc;
    logic                     zero;
    logic [LIM_W-1:0]         depth;
  } crc_dtag_t;
endpackage
`default_nettype wire

[rtl/circle_rect_collision_resolver.sv]
// ----------------------------------------------------------------------------
// circle_rect_collision_resolver: narrow-phase circle/rectangle push-out
// Stages in order: prep, square root, contact test, divider, scale, output register.
// Throughput: one word per cycle while the result side accepts; the 26-stage square root and the
// one-bit-per-stage divider set the depth, not the rate.
// A stall on the result side holds every stage at once; nothing drops.
// Reset (rst_n low, synchronous) clears all valid bits; data regs keep garbage.
// ----------------------------------------------------------------------------
`default_nettype none
module circle_rect_collision_resolver #(
  parameter int FRAC_BITS = crc_pkg::FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              in_a_is_rect,
  input  wire logic signed [crc_pkg::POS_W-1:0]  in_a_x,
  input  wire logic signed [crc_pkg::POS_W-1:0]  in_a_y,
  input  wire logic        [crc_pkg::SIZE_W-1:0] in_a_w,
  input  wire logic        [crc_pkg::SIZE_W-1:0] in_a_h,
  input  wire logic                              in_b_is_rect,
  input  wire logic signed [crc_pkg::POS_W-1:0]  in_b_x,
  input  wire logic signed [crc_pkg::POS_W-1:0]  in_b_y,
  input  wire logic        [crc_pkg::SIZE_W-1:0] in_b_w,
  input  wire logic        [crc_pkg::SIZE_W-1:0] in_b_h,
  input  wire logic                              in_b_dynamic,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_hit,
  output logic signed [crc_pkg::POS_W-1:0]       out_a_dx,
  output logic signed [crc_pkg::POS_W-1:0]       out_a_dy,
  output logic signed [crc_pkg::POS_W-1:0]       out_b_dx,
  output logic signed [crc_pkg::POS_W-1:0]       out_b_dy
);
  localparam int LW = crc_pkg::LIM_W;
  localparam int PW = crc_pkg::PUSH_W;
  localparam int OW = crc_pkg::POS_W;
  localparam int MULW = FRAC_BITS + 1 + LW;

  // Advance the whole pipe unless a finished word waits at the output.
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Vector setup, squares and rectangle pairs.
  logic                       pv;
  logic [crc_pkg::RAD_W-1:0]  prad;
  crc_pkg::crc_tag_t          ptag;

  crc_prep u_prep (
    .clk, .rst_n, .en(adv), .in_v(in_valid),
    .a_is_rect(in_a_is_rect), .a_x(in_a_x), .a_y(in_a_y), .a_w(in_a_w), .a_h(in_a_h),
    .b_is_rect(in_b_is_rect), .b_x(in_b_x), .b_y(in_b_y), .b_w(in_b_w), .b_h(in_b_h),
    .b_dynamic(in_b_dynamic),
    .out_v(pv), .rad(prad), .tag(ptag)
  );

  // Distance.
  logic                        sv;
  logic [crc_pkg::ROOT_W-1:0]  slen;
  crc_pkg::crc_tag_t           stag;

  crc_sqrt u_sqrt (
    .clk, .rst_n, .en(adv), .in_v(pv), .rad(prad), .in_tag(ptag),
    .out_v(sv), .root(slen), .out_tag(stag)
  );

  // Contact test and depth. A hit implies len < lim, so len fits LIM_W bits.
  logic               cv_r;
  logic [LW-1:0]      cmx_r, cmy_r, clen_r;
  crc_pkg::crc_dtag_t ctag_r, ctag_nxt;
  logic [LW-1:0]      dep;

  always_comb begin
    dep = stag.lim - slen[LW-1:0];
    ctag_nxt = '0;
    ctag_nxt.rect_pair = stag.rect_pair;
    ctag_nxt.rect_hit  = stag.rect_hit;
    ctag_nxt.rdx       = stag.rdx;
    ctag_nxt.rdy       = stag.rdy;
    ctag_nxt.dyn       = stag.dyn;
    ctag_nxt.neg       = stag.neg;
    ctag_nxt.sx        = stag.sx;
    ctag_nxt.sy        = stag.sy;
    ctag_nxt.hitc      = slen < crc_pkg::ROOT_W'(stag.lim);
    // a zero-length normal gives no push
    ctag_nxt.zero      = slen == '0;
    ctag_nxt.depth     = stag.dyn ? (dep >> 1) : dep;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r <= 1'b0;
    end else if (adv) begin
      cv_r <= sv;
    end
    if (adv) begin
      cmx_r  <= stag.mx;
      cmy_r  <= stag.my;
      clen_r <= slen[LW-1:0];
      ctag_r <= ctag_nxt;
    end
  end

  // Unit normal, FRAC_BITS fractional bits, never above one.
  logic               dv;
  logic [FRAC_BITS:0] dqx, dqy;
  crc_pkg::crc_dtag_t dtag;

  crc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk, .rst_n, .en(adv), .in_v(cv_r), .mx(cmx_r), .my(cmy_r), .len(clen_r),
    .in_tag(ctag_r), .out_v(dv), .qx(dqx), .qy(dqy), .out_tag(dtag)
  );

  // Scale normal by depth.
  logic               mv_r;
  logic [MULW-1:0]    mpx_r, mpy_r;
  crc_pkg::crc_dtag_t mtag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r <= 1'b0;
    end else if (adv) begin
      mv_r <= dv;
    end
    if (adv) begin
      mpx_r  <= MULW'(dqx) * MULW'(dtag.depth);
      mpy_r  <= MULW'(dqy) * MULW'(dtag.depth);
      mtag_r <= dtag;
    end
  end

  // Apply signs, pick rectangle or circle result, register the output word.
  logic signed [PW-1:0] sax, say, ax, ay, bx, by;
  logic                 hit_nxt, cgo;

  always_comb begin
    sax = $signed({1'b0, mpx_r[FRAC_BITS +: LW]});
    say = $signed({1'b0, mpy_r[FRAC_BITS +: LW]});
    cgo = mtag_r.hitc && !mtag_r.zero;
    if (mtag_r.rect_pair) begin
      hit_nxt = mtag_r.rect_hit;
      ax = mtag_r.rdx;
      ay = mtag_r.rdy;
    end else begin
      hit_nxt = mtag_r.hitc;
      ax = !cgo ? '0 : ((mtag_r.sx ^ mtag_r.neg) ? -sax : sax);
      ay = !cgo ? '0 : ((mtag_r.sy ^ mtag_r.neg) ? -say : say);
    end
    bx = mtag_r.dyn ? -ax : '0;
    by = mtag_r.dyn ? -ay : '0;
  end

  logic                 ov_r, ohit_r;
  logic signed [OW-1:0] oax_r, oay_r, obx_r, oby_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (adv) begin
      ov_r <= mv_r;
    end
    if (adv) begin
      // push values stay within PUSH_W bits, so widening is the saturation
      ohit_r <= hit_nxt;
      oax_r  <= OW'(ax);
      oay_r  <= OW'(ay);
      obx_r  <= OW'(bx);
      oby_r  <= OW'(by);
    end
  end

  assign out_valid = ov_r;
  assign out_hit   = ohit_r;
  assign out_a_dx  = oax_r;
  assign out_a_dy  = oay_r;
  assign out_b_dx  = obx_r;
  assign out_b_dy  = oby_r;
endmodule
`default_nettype wire

[rtl/crc_prep.sv]
// ----------------------------------------------------------------------------
// crc_prep: separation vectors, squares and rectangle pair resolution
// Three register stages: vector/overlap, squares, square sum.
// ----------------------------------------------------------------------------
`default_nettype none
module crc_prep (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              en,
  input  wire logic                              in_v,
  input  wire logic                              a_is_rect,
  input  wire logic signed [crc_pkg::POS_W-1:0]  a_x,
  input  wire logic signed [crc_pkg::POS_W-1:0]  a_y,
  input  wire logic        [crc_pkg::SIZE_W-1:0] a_w,
  input  wire logic        [crc_pkg::SIZE_W-1:0] a_h,
  input  wire logic                              b_is_rect,
  input  wire logic signed [crc_pkg::POS_W-1:0]  b_x,
  input  wire logic signed [crc_pkg::POS_W-1:0]  b_y,
  input  wire logic        [crc_pkg::SIZE_W-1:0] b_w,
  input  wire logic        [crc_pkg::SIZE_W-1:0] b_h,
  input  wire logic                              b_dynamic,
  output logic                                   out_v,
  output logic             [crc_pkg::RAD_W-1:0]  rad,
  output crc_pkg::crc_tag_t                      tag
);
  localparam int VW = crc_pkg::VEC_W;
  localparam int LW = crc_pkg::LIM_W;
  localparam int PW = crc_pkg::PUSH_W;

  // stage 1
  logic                 v1_r, neg1_r, dyn1_r, rp1_r, xlt1_r, ylt1_r;
  logic signed [VW-1:0] vx1_r, vy1_r, ox1_r, oy1_r;
  logic [LW-1:0]        lim1_r;
  // stage 2
  logic                         v2_r;
  logic [crc_pkg::SQ_W-1:0]     sqx2_r, sqy2_r;
  crc_pkg::crc_tag_t            tag2_r;
  // stage 3
  logic                         v3_r;
  logic [crc_pkg::RAD_W-1:0]    rad3_r;
  crc_pkg::crc_tag_t            tag3_r;

  logic signed [VW-1:0] cx, cy, rx, ry, lox, hix, loy, hiy, clx, cly;
  logic signed [VW-1:0] vx_nxt, vy_nxt, dxab, dyab, madx, mady, ox_nxt, oy_nxt;
  logic [crc_pkg::SIZE_W-1:0] rw, rh;
  logic [LW-1:0] lim_nxt, sw, sh;
  logic cc;

  always_comb begin
    cc = !a_is_rect && !b_is_rect;
    if (a_is_rect) begin
      cx = VW'(b_x); cy = VW'(b_y); rx = VW'(a_x); ry = VW'(a_y); rw = a_w; rh = a_h;
    end else begin
      cx = VW'(a_x); cy = VW'(a_y); rx = VW'(b_x); ry = VW'(b_y); rw = b_w; rh = b_h;
    end
    lox = rx - $signed({7'd0, rw[crc_pkg::SIZE_W-1:1]});
    hix = rx + $signed({7'd0, rw[crc_pkg::SIZE_W-1:1]});
    loy = ry - $signed({7'd0, rh[crc_pkg::SIZE_W-1:1]});
    hiy = ry + $signed({7'd0, rh[crc_pkg::SIZE_W-1:1]});
    clx = (cx > hix) ? hix : ((cx < lox) ? lox : cx);
    cly = (cy > hiy) ? hiy : ((cy < loy) ? loy : cy);
    dxab = VW'(a_x) - VW'(b_x);
    dyab = VW'(a_y) - VW'(b_y);
    if (cc) begin
      vx_nxt = -dxab;
      vy_nxt = -dyab;
    end else begin
      vx_nxt = clx - cx;
      vy_nxt = cly - cy;
    end
    sw = LW'(a_w) + LW'(b_w);
    sh = LW'(a_h) + LW'(b_h);
    lim_nxt = cc ? sw : (a_is_rect ? LW'(b_w) : LW'(a_w));
    madx = dxab[VW-1] ? -dxab : dxab;
    mady = dyab[VW-1] ? -dyab : dyab;
    ox_nxt = $signed({6'd0, sw[LW-1:1]}) - madx;
    oy_nxt = $signed({6'd0, sh[LW-1:1]}) - mady;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
    end
    if (en) begin
      vx1_r  <= vx_nxt;
      vy1_r  <= vy_nxt;
      ox1_r  <= ox_nxt;
      oy1_r  <= oy_nxt;
      lim1_r <= lim_nxt;
      neg1_r <= !a_is_rect;
      dyn1_r <= b_dynamic;
      rp1_r  <= a_is_rect && b_is_rect;
      xlt1_r <= dxab[VW-1];
      ylt1_r <= dyab[VW-1];
    end
  end

  // stage 2: squares and rectangle push
  logic [crc_pkg::MAG_W-1:0] mx2, my2;
  logic signed [PW-1:0] px, py;
  crc_pkg::crc_tag_t tag2_nxt;

  always_comb begin
    mx2 = crc_pkg::MAG_W'(vx1_r[VW-1] ? -vx1_r : vx1_r);
    my2 = crc_pkg::MAG_W'(vy1_r[VW-1] ? -vy1_r : vy1_r);
    px  = dyn1_r ? (PW'(ox1_r) >>> 1) : PW'(ox1_r);
    py  = dyn1_r ? (PW'(oy1_r) >>> 1) : PW'(oy1_r);
    tag2_nxt = '0;
    tag2_nxt.rect_pair = rp1_r;
    tag2_nxt.rect_hit  = (ox1_r > 0) && (oy1_r > 0);
    if (tag2_nxt.rect_hit) begin
      // equal overlaps separate along y
      if (ox1_r < oy1_r) begin
        tag2_nxt.rdx = xlt1_r ? -px : px;
      end else begin
        tag2_nxt.rdy = ylt1_r ? -py : py;
      end
    end
    tag2_nxt.dyn = dyn1_r;
    tag2_nxt.neg = neg1_r;
    tag2_nxt.sx  = vx1_r[VW-1];
    tag2_nxt.sy  = vy1_r[VW-1];
    tag2_nxt.mx  = mx2[LW-1:0];
    tag2_nxt.my  = my2[LW-1:0];
    tag2_nxt.lim = lim1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    if (en) begin
      sqx2_r <= mx2 * mx2;
      sqy2_r <= my2 * my2;
      tag2_r <= tag2_nxt;
      rad3_r <= crc_pkg::RAD_W'(sqx2_r) + crc_pkg::RAD_W'(sqy2_r);
      tag3_r <= tag2_r;
    end
  end

  assign out_v = v3_r;
  assign rad   = rad3_r;
  assign tag   = tag3_r;
endmodule
`default_nettype wire

[rtl/crc_sqrt.sv]
// ----------------------------------------------------------------------------
// crc_sqrt: pipelined integer square root
// One result bit per stage, digit-by-digit restoring method.
// ----------------------------------------------------------------------------
`default_nettype none
module crc_sqrt (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             en,
  input  wire logic                             in_v,
  input  wire logic [crc_pkg::RAD_W-1:0]        rad,
  input  crc_pkg::crc_tag_t                     in_tag,
  output logic                                  out_v,
  output logic [crc_pkg::ROOT_W-1:0]            root,
  output crc_pkg::crc_tag_t                     out_tag
);
  localparam int NS = crc_pkg::SQ_STEPS;
  localparam int RW = crc_pkg::RAD_W;
  localparam int QW = crc_pkg::ROOT_W;
  localparam int MW = crc_pkg::REM_W;

  logic              v_r    [NS];
  logic [RW-1:0]     rad_r  [NS];
  logic [MW-1:0]     rem_r  [NS];
  logic [QW-1:0]     root_r [NS];
  crc_pkg::crc_tag_t tag_r  [NS];

  for (genvar k = 0; k < NS; k++) begin : g_step
    logic              vi;
    logic [RW-1:0]     radi;
    logic [MW-1:0]     remi, rem_nxt, trial;
    logic [QW-1:0]     rooti;
    crc_pkg::crc_tag_t tagi;
    if (k == 0) begin : g_first
      assign vi = in_v; assign radi = rad; assign remi = '0;
      assign rooti = '0; assign tagi = in_tag;
    end else begin : g_next
      assign vi = v_r[k-1]; assign radi = rad_r[k-1]; assign remi = rem_r[k-1];
      assign rooti = root_r[k-1]; assign tagi = tag_r[k-1];
    end
    assign rem_nxt = {remi[MW-3:0], radi[RW-1:RW-2]};
    assign trial   = {rooti, 2'b01};
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= vi;
      end
      if (en) begin
        rad_r[k] <= {radi[RW-3:0], 2'b00};
        tag_r[k] <= tagi;
        if (rem_nxt >= trial) begin
          rem_r[k]  <= rem_nxt - trial;
          root_r[k] <= {rooti[QW-2:0], 1'b1};
        end else begin
          rem_r[k]  <= rem_nxt;
          root_r[k] <= {rooti[QW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_v   = v_r[NS-1];
  assign root    = root_r[NS-1];
  assign out_tag = tag_r[NS-1];
endmodule
`default_nettype wire

[rtl/crc_div.sv]
// ----------------------------------------------------------------------------
// crc_div: pipelined normal divider
// Two restoring dividers side by side, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module crc_div #(
  parameter int FRAC_BITS = crc_pkg::FRAC_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire logic                       in_v,
  input  wire logic [crc_pkg::LIM_W-1:0]  mx,
  input  wire logic [crc_pkg::LIM_W-1:0]  my,
  input  wire logic [crc_pkg::LIM_W-1:0]  len,
  input  crc_pkg::crc_dtag_t              in_tag,
  output logic                            out_v,
  output logic [FRAC_BITS:0]              qx,
  output logic [FRAC_BITS:0]              qy,
  output crc_pkg::crc_dtag_t              out_tag
);
  localparam int NS = FRAC_BITS + 1;
  localparam int LW = crc_pkg::LIM_W;

  logic               v_r   [NS];
  logic [LW:0]        rx_r  [NS];
  logic [LW:0]        ry_r  [NS];
  logic [FRAC_BITS:0] qx_r  [NS];
  logic [FRAC_BITS:0] qy_r  [NS];
  logic [LW-1:0]      len_r [NS];
  crc_pkg::crc_dtag_t tag_r [NS];

  for (genvar k = 0; k < NS; k++) begin : g_step
    logic               vi, gex, gey;
    logic [LW:0]        rxn, ryn;
    logic [FRAC_BITS:0] qxi, qyi;
    logic [LW-1:0]      leni;
    crc_pkg::crc_dtag_t tagi;
    if (k == 0) begin : g_first
      // the first step brings in the whole magnitude; later steps shift in zeros
      assign vi = in_v; assign rxn = {1'b0, mx}; assign ryn = {1'b0, my};
      assign qxi = '0; assign qyi = '0; assign leni = len; assign tagi = in_tag;
    end else begin : g_next
      assign vi = v_r[k-1];
      assign rxn = {rx_r[k-1][LW-1:0], 1'b0};
      assign ryn = {ry_r[k-1][LW-1:0], 1'b0};
      assign qxi = qx_r[k-1]; assign qyi = qy_r[k-1];
      assign leni = len_r[k-1]; assign tagi = tag_r[k-1];
    end
    assign gex = rxn >= {1'b0, leni};
    assign gey = ryn >= {1'b0, leni};
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= vi;
      end
      if (en) begin
        rx_r[k]  <= gex ? (rxn - {1'b0, leni}) : rxn;
        ry_r[k]  <= gey ? (ryn - {1'b0, leni}) : ryn;
        qx_r[k]  <= {qxi[FRAC_BITS-1:0], gex};
        qy_r[k]  <= {qyi[FRAC_BITS-1:0], gey};
        len_r[k] <= leni;
        tag_r[k] <= tagi;
      end
    end
  end

  assign out_v   = v_r[NS-1];
  assign qx      = qx_r[NS-1];
  assign qy      = qy_r[NS-1];
  assign out_tag = tag_r[NS-1];
endmodule
`default_nettype wire

[tb/sv/tb_circle_rect_collision_resolver.sv]
// ----------------------------------------------------------------------------
// tb_circle_rect_collision_resolver: self-checking bench for the resolver
// A short directed table covers the special contact cases and the field
// extremes. Random body pairs follow, mostly placed close enough to touch.
// Every result word is checked against a typed-in expectation or a fixed-point push-out predictor.
// Both handshake sides idle in random bursts, except at the end of the run.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_circle_rect_collision_resolver;
  localparam int FB = crc_pkg::FRAC_BITS_DEF;
  localparam int PSW = crc_pkg::POS_W;
  localparam int SZW = crc_pkg::SIZE_W;
  localparam int N_RANDOM = 1600;
  localparam int N_CALM = 200;     // last random words sent with no idling
  localparam int DRAIN_CYCLES = 60; // a bit more than the pipeline depth

  // One input word: a pair of bodies.
  typedef struct {
    logic                  a_is_rect;
    logic signed [PSW-1:0] a_x, a_y;
    logic        [SZW-1:0] a_w, a_h;
    logic                  b_is_rect;
    logic signed [PSW-1:0] b_x, b_y;
    logic        [SZW-1:0] b_w, b_h;
    logic                  b_dynamic;
  } pair_t;

  // One result word: the push-out displacements.
  typedef struct {
    logic                  hit;
    logic signed [PSW-1:0] a_dx, a_dy, b_dx, b_dy;
  } push_t;

  typedef struct {
    pair_t p;
    bit    fixed;   // expectation typed in below rather than predicted
    push_t r;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_a_is_rect = 1'b0;
  logic signed [PSW-1:0] in_a_x = '0, in_a_y = '0;
  logic [SZW-1:0] in_a_w = '0, in_a_h = '0;
  logic in_b_is_rect = 1'b0;
  logic signed [PSW-1:0] in_b_x = '0, in_b_y = '0;
  logic [SZW-1:0] in_b_w = '0, in_b_h = '0;
  logic in_b_dynamic = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_hit;
  logic signed [PSW-1:0] out_a_dx, out_a_dy, out_b_dx, out_b_dy;

  push_t push_q[$];     // expected pushes, oldest first
  int    n_fail = 0;
  bit    calm = 1'b0;   // set for the tail of the run: no idling anywhere
  bit    sent_all = 1'b0;

  circle_rect_collision_resolver uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_a_is_rect(in_a_is_rect), .in_a_x(in_a_x), .in_a_y(in_a_y),
    .in_a_w(in_a_w), .in_a_h(in_a_h),
    .in_b_is_rect(in_b_is_rect), .in_b_x(in_b_x), .in_b_y(in_b_y),
    .in_b_w(in_b_w), .in_b_h(in_b_h), .in_b_dynamic(in_b_dynamic),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_hit(out_hit), .out_a_dx(out_a_dx), .out_a_dy(out_a_dy),
    .out_b_dx(out_b_dx), .out_b_dy(out_b_dy)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Push-out predictor, all in 64-bit integers
  // --------------------------------------------------------------------------
  function automatic longint unsigned mag(longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  function automatic longint root_floor(longint unsigned x);
    longint unsigned res = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  // One normal component; zero for a zero-length vector.
  function automatic longint unit_comp(longint v, longint len);
    longint q;
    if (len <= 0) return 0;
    q = longint'((mag(v) << FB) / longint'(len));
    return (v < 0) ? -q : q;
  endfunction

  // Normal component times a non-negative depth, truncated toward zero.
  function automatic longint scale_depth(longint n, longint d);
    longint q;
    q = longint'((mag(n) * longint'(d)) >> FB);
    return (n < 0) ? -q : q;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v;
  endfunction

  function automatic push_t predict_push(pair_t p);
    push_t  r;
    longint ax, ay, aw, ah, bx, by, bw, bh;
    longint vx, vy, len, lim, depth, sgn, ox, oy, pd;
    longint adx, ady, bdx, bdy;
    ax = longint'(p.a_x); ay = longint'(p.a_y);
    bx = longint'(p.b_x); by = longint'(p.b_y);
    aw = longint'({1'b0, p.a_w}); ah = longint'({1'b0, p.a_h});
    bw = longint'({1'b0, p.b_w}); bh = longint'({1'b0, p.b_h});
    adx = 0; ady = 0; bdx = 0; bdy = 0;
    r.hit = 1'b0;
    if (!p.a_is_rect || !p.b_is_rect) begin
      if (!p.a_is_rect && !p.b_is_rect) begin
        vx = bx - ax; vy = by - ay; lim = aw + bw; sgn = -1;
      end else if (!p.a_is_rect) begin
        // circle A against rectangle B: nearest point of B to A's centre
        vx = clip(ax, bx - (bw >> 1), bx + (bw >> 1)) - ax;
        vy = clip(ay, by - (bh >> 1), by + (bh >> 1)) - ay;
        lim = aw; sgn = -1;
      end else begin
        // rectangle A against circle B: depth uses B's radius
        vx = clip(bx, ax - (aw >> 1), ax + (aw >> 1)) - bx;
        vy = clip(by, ay - (ah >> 1), ay + (ah >> 1)) - by;
        lim = bw; sgn = 1;
      end
      len = root_floor(mag(vx) * mag(vx) + mag(vy) * mag(vy));
      if (len < lim) begin
        r.hit = 1'b1;
        depth = lim - len;
        if (p.b_dynamic) depth >>= 1;
        adx = sgn * scale_depth(unit_comp(vx, len), depth);
        ady = sgn * scale_depth(unit_comp(vy, len), depth);
        if (p.b_dynamic) begin
          bdx = -adx; bdy = -ady;
        end
      end
    end else begin
      ox = ((aw + bw) >> 1) - longint'(mag(ax - bx));
      oy = ((ah + bh) >> 1) - longint'(mag(ay - by));
      if (ox > 0 && oy > 0) begin
        r.hit = 1'b1;
        // separate along the smaller overlap; a tie goes to y
        if (ox < oy) begin
          pd = p.b_dynamic ? (ox >> 1) : ox;
          adx = (ax < bx) ? -pd : pd;
          if (p.b_dynamic) bdx = -adx;
        end else begin
          pd = p.b_dynamic ? (oy >> 1) : oy;
          ady = (ay < by) ? -pd : pd;
          if (p.b_dynamic) bdy = -ady;
        end
      end
    end
    r.a_dx = PSW'(clip(adx, -8388608, 8388607));
    r.a_dy = PSW'(clip(ady, -8388608, 8388607));
    r.b_dx = PSW'(clip(bdx, -8388608, 8388607));
    r.b_dy = PSW'(clip(bdy, -8388608, 8388607));
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic pair_t mk_pair(bit ar, int ax, int ay, int aw, int ah,
                                    bit br, int bx, int by, int bw, int bh, bit dyn);
    pair_t p;
    p.a_is_rect = ar; p.a_x = PSW'(ax); p.a_y = PSW'(ay);
    p.a_w = SZW'(aw); p.a_h = SZW'(ah);
    p.b_is_rect = br; p.b_x = PSW'(bx); p.b_y = PSW'(by);
    p.b_w = SZW'(bw); p.b_h = SZW'(bh);
    p.b_dynamic = dyn;
    return p;
  endfunction

  function automatic push_t mk_push(bit h, int adx, int ady, int bdx, int bdy);
    push_t r;
    r.hit = h; r.a_dx = PSW'(adx); r.a_dy = PSW'(ady);
    r.b_dx = PSW'(bdx); r.b_dy = PSW'(bdy);
    return r;
  endfunction

  // Random pair; most are placed close so that they tend to touch.
  function automatic pair_t rand_pair();
    pair_t p;
    int    span;
    p.a_is_rect = 1'($urandom_range(0, 1));
    p.b_is_rect = 1'($urandom_range(0, 1));
    p.b_dynamic = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 9) == 0) begin
      // noise: any value of every field
      p.a_x = PSW'($urandom); p.a_y = PSW'($urandom);
      p.b_x = PSW'($urandom); p.b_y = PSW'($urandom);
      p.a_w = SZW'($urandom); p.a_h = SZW'($urandom);
      p.b_w = SZW'($urandom); p.b_h = SZW'($urandom);
    end else begin
      span = ($urandom_range(0, 7) == 0) ? 20'hFFFFF : 20'h03FFF;
      p.a_w = SZW'($urandom_range(0, span)); p.a_h = SZW'($urandom_range(0, span));
      p.b_w = SZW'($urandom_range(0, span)); p.b_h = SZW'($urandom_range(0, span));
      p.a_x = PSW'($urandom); p.a_y = PSW'($urandom);
      // offsets mostly inside the combined size, sometimes aligned
      p.b_x = PSW'(p.a_x + ($urandom_range(0, 5) == 0 ? 0 :
                            $signed($urandom_range(0, 2 * span)) - span));
      p.b_y = PSW'(p.a_y + ($urandom_range(0, 5) == 0 ? 0 :
                            $signed($urandom_range(0, 2 * span)) - span));
    end
    return p;
  endfunction

  // Drive one word and hold it until accepted. Enter and leave at a posedge.
  task automatic send_pair(pair_t p);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_a_is_rect <= p.a_is_rect; in_a_x <= p.a_x; in_a_y <= p.a_y;
    in_a_w <= p.a_w; in_a_h <= p.a_h;
    in_b_is_rect <= p.b_is_rect; in_b_x <= p.b_x; in_b_y <= p.b_y;
    in_b_w <= p.b_w; in_b_h <= p.b_h;
    in_b_dynamic <= p.b_dynamic;
    do @(posedge clk); while (!in_ready);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    row_t  rows[$];
    row_t  rw;
    pair_t p;
    int    i;

    // circles far apart: no contact
    rw.p = mk_pair(0, 0, 0, 256, 7, 0, 10000, 0, 256, 0, 0);
    rw.fixed = 1; rw.r = mk_push(0, 0, 0, 0, 0); rows.insert(rows.size(), rw);
    // coincident circle centres: contact with a zero normal
    rw.p = mk_pair(0, 500, -500, 256, 0, 0, 500, -500, 300, 0, 1);
    rw.fixed = 1; rw.r = mk_push(1, 0, 0, 0, 0); rows.insert(rows.size(), rw);
    // zero radii at the same spot never touch
    rw.p = mk_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    rw.fixed = 1; rw.r = mk_push(0, 0, 0, 0, 0); rows.insert(rows.size(), rw);
    // circle centre inside a rectangle: zero normal
    rw.p = mk_pair(0, 0, 0, 256, 0, 1, 0, 0, 512, 512, 0);
    rw.fixed = 1; rw.r = mk_push(1, 0, 0, 0, 0); rows.insert(rows.size(), rw);
    // rectangles on one centre, equal overlaps: push along +y
    rw.p = mk_pair(1, 0, 0, 256, 256, 1, 0, 0, 256, 256, 0);
    rw.fixed = 1; rw.r = mk_push(1, 0, 256, 0, 0); rows.insert(rows.size(), rw);
    rw.p = mk_pair(1, 0, 0, 256, 256, 1, 0, 0, 256, 256, 1);
    rw.fixed = 1; rw.r = mk_push(1, 0, 128, 0, -128); rows.insert(rows.size(), rw);
    // rectangles exactly touching: overlap of zero is no contact
    rw.p = mk_pair(1, 0, 0, 256, 256, 1, 256, 0, 256, 256, 1);
    rw.fixed = 1; rw.r = mk_push(0, 0, 0, 0, 0); rows.insert(rows.size(), rw);

    // the rest come from the predictor
    rw.fixed = 0;
    rw.p = mk_pair(0, 0, 0, 300, 0, 0, 200, 150, 100, 0, 0); rows.insert(rows.size(), rw);
    rw.p = mk_pair(0, 0, 0, 300, 0, 0, -200, -150, 100, 0, 1); rows.insert(rows.size(), rw);
    rw.p = mk_pair(0, 0, 0, 200, 99, 1, 250, 30, 256, 512, 0); rows.insert(rows.size(), rw);
    rw.p = mk_pair(0, 0, 0, 200, 0, 1, -250, -300, 256, 512, 1);
    rows.insert(rows.size(), rw);
    // rectangle A, circle B, dynamic and static: depth from B's radius
    rw.p = mk_pair(1, 0, 0, 512, 256, 0, 300, 200, 180, 5, 1); rows.insert(rows.size(), rw);
    rw.p = mk_pair(1, 0, 0, 512, 256, 0, -300, -200, 180, 0, 0);
    rows.insert(rows.size(), rw);
    // rectangles: x overlap smaller on both sides of B, then a smaller y overlap
    rw.p = mk_pair(1, -100, 10, 300, 900, 1, 100, 0, 300, 900, 0);
    rows.insert(rows.size(), rw);
    rw.p = mk_pair(1, 100, 10, 300, 900, 1, -100, 0, 300, 900, 1);
    rows.insert(rows.size(), rw);
    rw.p = mk_pair(1, 7, -80, 900, 300, 1, 0, 80, 900, 300, 1); rows.insert(rows.size(), rw);
    // field extremes
    rw.p = mk_pair(0, 8388607, 8388607, 1048575, 1048575,
                   0, -8388608, -8388608, 1048575, 1048575, 1);
    rows.insert(rows.size(), rw);
    rw.p = mk_pair(1, 8388607, -8388608, 1048575, 1048575,
                   1, 8388607, -8388608, 1048575, 1048575, 1);
    rows.insert(rows.size(), rw);
    rw.p = mk_pair(1, -8388608, 8388607, 1048575, 1048575,
                   1, -8388608, 8388607, 1048575, 1048575, 0);
    rows.insert(rows.size(), rw);
    rw.p = mk_pair(0, 8388000, 0, 1048575, 0, 1, 8388607, 1000, 1048575, 1, 0);
    rows.insert(rows.size(), rw);
    rw.p = mk_pair(1, -8388608, 0, 0, 0, 0, -8388608, 0, 1048575, 0, 1);
    rows.insert(rows.size(), rw);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[k]) begin
      send_pair(rows[k].p);
      push_q.insert(push_q.size(),
                    rows[k].fixed ? rows[k].r : predict_push(rows[k].p));
    end

    for (i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - N_CALM) calm = 1'b1;
      p = rand_pair();
      send_pair(p);
      push_q.insert(push_q.size(), predict_push(p));
    end
    in_valid <= 1'b0;
    sent_all = 1'b1;

    // drain every outstanding push, then let the pipe settle
    while (push_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_fail == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Result side backpressure: random stall bursts until the calm tail.
  initial begin
    int run;
    @(posedge clk);
    while (1) begin
      if (calm || sent_all) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        run = $urandom_range(1, 30);
        out_ready <= 1'b1;
        repeat (run) @(posedge clk);
      end
    end
  end

  // Check each accepted result word against the oldest expectation.
  always @(posedge clk) begin
    push_t e;
    if (rst_n && out_valid && out_ready) begin
      if (push_q.size() == 0) begin
        $error("result word with no expectation pending");
        n_fail++;
      end else begin
        e = push_q.pop_front();
        if (out_hit !== e.hit) begin
          $error("hit: expected %0d, actual %0d", e.hit, out_hit); n_fail++;
        end
        if (out_a_dx !== e.a_dx) begin
          $error("a_dx: expected %0d, actual %0d", e.a_dx, out_a_dx); n_fail++;
        end
        if (out_a_dy !== e.a_dy) begin
          $error("a_dy: expected %0d, actual %0d", e.a_dy, out_a_dy); n_fail++;
        end
        if (out_b_dx !== e.b_dx) begin
          $error("b_dx: expected %0d, actual %0d", e.b_dx, out_b_dx); n_fail++;
        end
        if (out_b_dy !== e.b_dy) begin
          $error("b_dy: expected %0d, actual %0d", e.b_dy, out_b_dy); n_fail++;
        end
      end
    end
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20000000;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
`default_nettype wire

[files.f]
rtl/crc_pkg.sv
rtl/crc_prep.sv
rtl/crc_sqrt.sv
rtl/crc_div.sv
rtl/circle_rect_collision_resolver.sv
tb/sv/tb_circle_rect_collision_resolver.sv
